[design/rkn_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rkn_pkg - shared types for the running k-th nearest point core
// word layouts of both channels, the sort key and the cell link structs
// ----------------------------------------------------------------------------
package rkn_pkg;

  localparam int KEY_W   = 64;
  localparam int COORD_W = 16;
  localparam int DIST_W  = 32;
  localparam int RANK_W  = 7;

  // register index on the config port
  localparam logic REG_RANK_K = 1'b0;

  // flips the sign bit so signed coords order as unsigned
  localparam logic [COORD_W-1:0] SIGN_FLIP = 16'h8000;

  typedef struct packed {
    logic signed [COORD_W-1:0] x_coord;
    logic signed [COORD_W-1:0] y_coord;
    logic                      start_set;
    logic                      report;
  } pt_word_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] kth_x;
    logic signed [COORD_W-1:0] kth_y;
    logic        [DIST_W-1:0]  kth_dist;
    logic                      kth_valid;
  } res_word_t;

  // key broadcast to every cell in the chain
  typedef struct packed {
    logic             ins;
    logic [KEY_W-1:0] key;
  } rkn_bcast_t;

  // what a cell hands to its right-hand neighbor
  typedef struct packed {
    logic             after;
    logic [KEY_W-1:0] key;
  } rkn_link_t;

endpackage : rkn_pkg
`default_nettype wire

[design/rkn_key.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rkn_key - sort key front stage
// squares both coordinates and registers the packed distance/x/y key
// ----------------------------------------------------------------------------
module rkn_key
  import rkn_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             load,
  input  wire pt_word_t         pt,
  output logic                  key_valid,
  output logic [KEY_W-1:0]      key,
  output logic                  key_start,
  output logic                  key_report
);

  logic [COORD_W:0]   ax;
  logic [COORD_W:0]   ay;
  logic [DIST_W-1:0]  sq_dist;
  logic [KEY_W-1:0]   key_next;

  // magnitude needs 17 bits for -32768
  assign ax = pt.x_coord[COORD_W-1] ? ((COORD_W+1)'(0) - {pt.x_coord[COORD_W-1], pt.x_coord})
                                    : {1'b0, pt.x_coord};
  assign ay = pt.y_coord[COORD_W-1] ? ((COORD_W+1)'(0) - {pt.y_coord[COORD_W-1], pt.y_coord})
                                    : {1'b0, pt.y_coord};

  // widen before squaring so the products keep all their bits
  assign sq_dist = DIST_W'(ax) * DIST_W'(ax) + DIST_W'(ay) * DIST_W'(ay);

  assign key_next = {sq_dist, pt.x_coord ^ SIGN_FLIP, pt.y_coord ^ SIGN_FLIP};

  always_ff @(posedge clk) begin
    if (rst) begin
      key_valid <= 1'b0;
    end else begin
      key_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      key        <= key_next;
      key_start  <= pt.start_set;
      key_report <= pt.report;
    end
  end

endmodule : rkn_key
`default_nettype wire

[design/rkn_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rkn_cell - one slot of the sorted chain
// holds one key; on insert it keeps, takes the new key or takes its neighbor's
// ----------------------------------------------------------------------------
module rkn_cell
  import rkn_pkg::*;
(
  input  wire logic       clk,
  input  wire rkn_bcast_t bcast,
  input  wire logic       occupied,
  input  wire rkn_link_t  prev,
  output rkn_link_t       link
);

  logic [KEY_W-1:0] key;
  logic             after;

  // empty slots behave as +infinity
  assign after = !occupied || (key > bcast.key);

  assign link.after = after;
  assign link.key   = key;

  always_ff @(posedge clk) begin
    if (bcast.ins && after) begin
      key <= prev.after ? prev.key : bcast.key;
    end
  end

endmodule : rkn_cell
`default_nettype wire

[design/running_kth_nearest_point_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// running_kth_nearest_point_core - running k-th nearest point of a stream
// keeps the K_MAX nearest points since the last set start in a sorted chain
// of cells and reports the rank_k-th of them on request
// ----------------------------------------------------------------------------
// Points enter as one word on the pt channel. A point without the report flag
// is taken every cycle. A point with the report flag holds the pt channel
// until the chain has been read at rank_k after its insertion and that read
// has landed in the result register, longer while the result register is
// full and stalled. The result word passes the key stage (squares), the
// chain insert and the result register.
// The chain holds K_MAX cells sorted by squared distance, then x, then y;
// a new key is broadcast to all cells at once and every cell that
// holds a larger key (or is empty) shifts right by one. With the chain full,
// the largest key falls off the end. rank_k is written over the APB port at
// byte address 0; rank zero or above K_MAX returns a word with kth_valid low
// and all other fields zero, as does a rank not yet reached by the set.
// ----------------------------------------------------------------------------
module running_kth_nearest_point_core
  import rkn_pkg::*;
#(
  parameter int K_MAX = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // point channel
  input  wire logic        pt_valid,
  output logic             pt_stall,
  input  wire pt_word_t    pt,
  // result channel
  output logic             res_valid,
  input  wire logic        res_stall,
  output res_word_t        res,
  // config port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int CNT_W = $clog2(K_MAX + 1);
  localparam int CMP_W = (CNT_W > RANK_W) ? CNT_W : RANK_W;

  // config register
  logic [RANK_W-1:0] rank_k;

  // front stage
  logic              pt_acc;
  logic              s1_valid;
  logic [KEY_W-1:0]  s1_key;
  logic              s1_start;
  logic              s1_report;

  // chain control
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_eff;
  logic [CNT_W-1:0]  count_next;
  logic              pending;
  logic              load_res;
  rkn_bcast_t        bcast;
  rkn_link_t         links [K_MAX+1];

  // chain read at rank
  logic [CMP_W-1:0]  rank_ext;
  logic [CMP_W-1:0]  count_ext;
  logic              rank_ok;
  logic [KEY_W-1:0]  sel_key;
  res_word_t         res_next;

  // --------------------------------------------------------------------------
  // config port, always ready, one register at word index 0
  // --------------------------------------------------------------------------
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rank_k <= RANK_W'(1);
    end else if (psel && penable && pwrite && (paddr[2] == REG_RANK_K)) begin
      rank_k <= pwdata[RANK_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_RANK_K) begin
      prdata = {{(32-RANK_W){1'b0}}, rank_k};
    end
  end

  // --------------------------------------------------------------------------
  // input side: a reporting point in flight blocks the next word until the
  // chain has been read for it
  // --------------------------------------------------------------------------
  assign pt_stall = pending || (s1_valid && s1_report);
  assign pt_acc   = pt_valid && !pt_stall;

  rkn_key u_key (
    .clk        (clk),
    .rst        (rst),
    .load       (pt_acc),
    .pt         (pt),
    .key_valid  (s1_valid),
    .key        (s1_key),
    .key_start  (s1_start),
    .key_report (s1_report)
  );

  // --------------------------------------------------------------------------
  // fill count: a set start empties the chain before the insert
  // --------------------------------------------------------------------------
  assign count_eff  = s1_start ? '0 : count;
  assign count_next = (count_eff < CNT_W'(K_MAX)) ? count_eff + CNT_W'(1) : count_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (s1_valid) begin
      count <= count_next;
    end
  end

  // --------------------------------------------------------------------------
  // sorted chain; cell 0 sees an empty left neighbor that never shifts
  // --------------------------------------------------------------------------
  assign bcast.ins = s1_valid;
  assign bcast.key = s1_key;

  assign links[0].after = 1'b0;
  assign links[0].key   = '0;

  for (genvar gi = 0; gi < K_MAX; gi++) begin : g_cell
    rkn_cell u_cell (
      .clk      (clk),
      .bcast    (bcast),
      .occupied (CNT_W'(gi) < count_eff),
      .prev     (links[gi]),
      .link     (links[gi+1])
    );
  end

  // --------------------------------------------------------------------------
  // read at rank after a reporting insert, pending until the result register takes it
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 1'b0;
    end else if (load_res) begin
      pending <= 1'b0;
    end else if (s1_valid && s1_report) begin
      pending <= 1'b1;
    end
  end

  assign rank_ext  = CMP_W'(rank_k);
  assign count_ext = CMP_W'(count);
  assign rank_ok   = (rank_ext != '0) && (rank_ext <= CMP_W'(K_MAX)) &&
                     (count_ext >= rank_ext);

  // one-hot pick across the cells
  always_comb begin
    sel_key = '0;
    for (int i = 0; i < K_MAX; i++) begin
      if (rank_ext == CMP_W'(i + 1)) begin
        sel_key = sel_key | links[i+1].key;
      end
    end
  end

  always_comb begin
    res_next = '0;
    if (rank_ok) begin
      res_next.kth_x     = sel_key[2*COORD_W-1:COORD_W] ^ SIGN_FLIP;
      res_next.kth_y     = sel_key[COORD_W-1:0] ^ SIGN_FLIP;
      res_next.kth_dist  = sel_key[KEY_W-1:2*COORD_W];
      res_next.kth_valid = 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // result register
  // --------------------------------------------------------------------------
  assign load_res = pending && (!res_valid || !res_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load_res) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_res) begin
      res <= res_next;
    end
  end

  // --------------------------------------------------------------------------
  // checks
  // --------------------------------------------------------------------------
  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(K_MAX))
    else $error("fill count above chain length");

  a_start_count : assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_start) |=> (count == CNT_W'(1)))
    else $error("set start did not leave one point held");

  a_res_source : assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(pending))
    else $error("result word without a pending chain read");

  a_invalid_zero : assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res.kth_valid) |->
      (res.kth_dist == '0 && res.kth_x == '0 && res.kth_y == '0))
    else $error("invalid result word carries nonzero fields");

endmodule : running_kth_nearest_point_core
`default_nettype wire

[bench/kth_point_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kth_point_checker - scoreboard for the running k-th nearest point core
// tracks the rank register, keeps its own sorted copy of the nearest points
// and checks every result word against the oldest predicted one
// ----------------------------------------------------------------------------
module kth_point_checker
  import rkn_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        pt_valid,
  input  wire logic        pt_stall,
  input  wire pt_word_t    pt,
  input  wire logic        res_valid,
  input  wire logic        res_stall,
  input  wire res_word_t   res,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  input  wire logic        pready,
  output int               errors,
  output int               pending,
  output int               items_seen,
  output int               results_seen,
  output int               valid_seen,
  output int               overflow_seen
);

  localparam logic [2:0] RANK_ADDR  = {REG_RANK_K, 2'b00};
  localparam int         SHOW_LIMIT = 10;

  logic [KEY_W-1:0]  nearest_keys [DEPTH];
  int                held;
  logic [RANK_W-1:0] rank_sel;
  res_word_t         kth_expected [$];
  res_word_t         want;
  int                fail_count, item_count, result_count, valid_count, full_count;

  function automatic logic [KEY_W-1:0] point_key(input pt_word_t w);
    int                xi;
    int                yi;
    logic [DIST_W-1:0] ax;
    logic [DIST_W-1:0] ay;
    xi = int'(w.x_coord);
    yi = int'(w.y_coord);
    ax = DIST_W'((xi < 0) ? -xi : xi);
    ay = DIST_W'((yi < 0) ? -yi : yi);
    return {ax * ax + ay * ay, w.x_coord ^ SIGN_FLIP, w.y_coord ^ SIGN_FLIP};
  endfunction

  // ordered insert, largest key falls off once the store is full
  task automatic insert_point(input logic [KEY_W-1:0] key);
    int pos;
    if (held >= DEPTH) begin
      full_count++;
      if (key >= nearest_keys[DEPTH-1]) return;
      pos = DEPTH - 1;
    end else begin
      pos = held;
      held++;
    end
    while (pos > 0 && nearest_keys[pos-1] > key) begin
      nearest_keys[pos] = nearest_keys[pos-1];
      pos--;
    end
    nearest_keys[pos] = key;
  endtask

  function automatic res_word_t kth_word();
    res_word_t        r;
    logic [KEY_W-1:0] e;
    r = '0;
    if (rank_sel >= 1 && rank_sel <= DEPTH && held >= rank_sel) begin
      e           = nearest_keys[rank_sel-1];
      r.kth_x     = e[31:16] ^ SIGN_FLIP;
      r.kth_y     = e[15:0] ^ SIGN_FLIP;
      r.kth_dist  = e[63:32];
      r.kth_valid = 1'b1;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      held = 0;
      rank_sel = 1;
      kth_expected.delete();
      fail_count = 0;
      item_count = 0;
      result_count = 0;
      valid_count = 0;
      full_count = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == RANK_ADDR)
        rank_sel = pwdata[RANK_W-1:0];

      if (res_valid && !res_stall) begin
        result_count++;
        if (kth_expected.size() == 0) begin
          fail_count++;
          if (fail_count <= SHOW_LIMIT)
            $display("%0t: unexpected result word x=%0d y=%0d d=%0d v=%0b", $realtime,
                     res.kth_x, res.kth_y, res.kth_dist, res.kth_valid);
        end else begin
          want = kth_expected.pop_front();
          if (want.kth_valid) valid_count++;
          if (res.kth_x !== want.kth_x || res.kth_y !== want.kth_y ||
              res.kth_dist !== want.kth_dist || res.kth_valid !== want.kth_valid) begin
            fail_count++;
            if (fail_count <= SHOW_LIMIT)
              $display("%0t: result %0d expected x=%0d y=%0d d=%0d v=%0b got x=%0d y=%0d d=%0d v=%0b",
                       $realtime, result_count, want.kth_x, want.kth_y, want.kth_dist,
                       want.kth_valid, res.kth_x, res.kth_y, res.kth_dist, res.kth_valid);
          end
        end
      end

      if (pt_valid && !pt_stall) begin
        item_count++;
        if (pt.start_set) held = 0;
        insert_point(point_key(pt));
        if (pt.report) kth_expected.push_back(kth_word());
      end
    end
    errors        <= fail_count;
    pending       <= kth_expected.size();
    items_seen    <= item_count;
    results_seen  <= result_count;
    valid_seen    <= valid_count;
    overflow_seen <= full_count;
  end

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench - top of the running k-th nearest point bench
// drives point words and rank writes, stalls the result side at random and
// lets the checker judge every result word against its own sorted store
// ----------------------------------------------------------------------------
module testbench;
  import rkn_pkg::*;

  localparam int         K_MAX            = 64;
  localparam int         CLK_PERIOD       = 20;
  localparam int         RESET_CYCLES     = 6;
  localparam int         LIMIT_CYCLES     = 1_000_000;
  localparam int         LONG_HOLD_CYCLES = 300;
  // margin for the core to settle once no result word is owed
  localparam int         DRAIN_CYCLES     = 10;
  localparam int         NUM_PHASES       = 12;
  localparam logic [2:0] RANK_ADDR        = {REG_RANK_K, 2'b00};

  logic        clk;
  logic        rst;
  logic        pt_valid;
  logic        pt_stall;
  pt_word_t    pt;
  logic        res_valid;
  logic        res_stall;
  res_word_t   res;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int errors, pending, items_seen, results_seen, valid_seen, overflow_seen;

  // receiver controls, set by the stimulus process
  bit rx_calm;
  bit hold_req;

  running_kth_nearest_point_core #(.K_MAX(K_MAX)) dut (
    .clk(clk), .rst(rst),
    .pt_valid(pt_valid), .pt_stall(pt_stall), .pt(pt),
    .res_valid(res_valid), .res_stall(res_stall), .res(res),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  kth_point_checker #(.DEPTH(K_MAX)) u_checker (
    .clk(clk), .rst(rst),
    .pt_valid(pt_valid), .pt_stall(pt_stall), .pt(pt),
    .res_valid(res_valid), .res_stall(res_stall), .res(res),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .errors(errors), .pending(pending), .items_seen(items_seen),
    .results_seen(results_seen), .valid_seen(valid_seen),
    .overflow_seen(overflow_seen)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // hard stop in case the core locks up
  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("testbench: errors");
    $finish;
  end

  // mostly no gap, sometimes a short one, rarely a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // result side: random stall runs, or one long hold on request
  initial begin
    int stall_run;
    int free_run;
    stall_run = 0;
    free_run  = 0;
    res_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        stall_run = LONG_HOLD_CYCLES;
      end
      if (stall_run > 0) begin
        res_stall <= 1'b1;
        stall_run--;
      end else if (rx_calm || free_run > 0) begin
        res_stall <= 1'b0;
        if (free_run > 0) free_run--;
      end else begin
        free_run  = $urandom_range(0, 6);
        stall_run = gap_len();
        res_stall <= (stall_run > 0);
        if (stall_run > 0) stall_run--;
      end
    end
  end

  // one apb write: setup cycle, then access cycle until pready
  task automatic write_rank(input logic [RANK_W-1:0] rank);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= RANK_ADDR;
    pwdata  <= 32'(rank);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // offer one word and hold it until taken; returns at a falling edge
  task automatic send_point(input pt_word_t w);
    pt_valid <= 1'b1;
    pt       <= w;
    do @(posedge clk); while (pt_stall);
    @(negedge clk);
  endtask

  task automatic sender_gap(input int n);
    if (n > 0) begin
      pt_valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  // sender idles until every expected word is back, then the core settles
  task automatic drain();
    pt_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic pt_word_t pt_of(input int x, input int y, input bit st, input bit rep);
    pt_word_t w;
    w.x_coord   = x[15:0];
    w.y_coord   = y[15:0];
    w.start_set = st;
    w.report    = rep;
    return w;
  endfunction

  // span 0 picks from the corner values, otherwise a window around zero
  function automatic logic [15:0] rand_coord(input int span);
    int corners [6];
    int v;
    corners = '{-32768, -32767, -1, 0, 1, 32767};
    if (span == 0) return 16'(corners[$urandom_range(0, 5)]);
    if (span >= 32768) return 16'($urandom());
    v = $urandom_range(0, 2 * span);
    return 16'(v - span);
  endfunction

  function automatic int pick_span();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 0;
    if (r < 35) return 3;
    if (r < 60) return 40;
    if (r < 80) return 1000;
    return 32768;
  endfunction

  // sets opened by start_set with random content, some long enough to fill
  // the store, plus stray set starts as noise
  task automatic run_sets(input int count, input int rep_pct, input bit gaps);
    pt_word_t w;
    int       set_left;
    int       span;
    bit       opening;
    set_left = 0;
    span     = pick_span();
    for (int i = 0; i < count; i++) begin
      opening = 1'b0;
      if (set_left == 0) begin
        set_left = ($urandom_range(0, 99) < 65) ? $urandom_range(1, 90)
                                                : $urandom_range(100, 220);
        span     = pick_span();
        opening  = ($urandom_range(0, 99) < 92);
      end
      set_left--;
      w.x_coord   = rand_coord(($urandom_range(0, 99) < 8) ? 0 : span);
      w.y_coord   = rand_coord(($urandom_range(0, 99) < 8) ? 0 : span);
      w.start_set = opening || ($urandom_range(0, 99) < 2);
      w.report    = ($urandom_range(0, 99) < rep_pct);
      send_point(w);
      if (gaps) sender_gap(gap_len());
    end
  endtask

  initial begin
    int plan_rank  [NUM_PHASES];
    int plan_items [NUM_PHASES];
    int plan_rep   [NUM_PHASES];
    bit plan_gaps  [NUM_PHASES];

    rst      = 1'b1;
    pt_valid = 1'b0;
    pt       = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    rx_calm  = 1'b1;
    hold_req = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // ties on distance 25 resolve by x then by signed y; rank 3 starts
    // with fewer points than the rank
    write_rank(3);
    send_point(pt_of(5, 0, 1, 1));
    send_point(pt_of(0, -5, 0, 1));
    send_point(pt_of(-3, 4, 0, 1));
    send_point(pt_of(3, 4, 0, 1));
    send_point(pt_of(3, -4, 0, 1));
    send_point(pt_of(-32768, -32768, 0, 1));
    send_point(pt_of(32767, 32767, 0, 0));
    send_point(pt_of(-32768, 0, 0, 0));
    send_point(pt_of(0, -32768, 0, 1));
    // duplicates at the origin land in front
    send_point(pt_of(0, 0, 0, 0));
    send_point(pt_of(0, 0, 0, 1));
    // fresh set at the far corner, then equal points
    send_point(pt_of(-32768, -32768, 1, 1));
    send_point(pt_of(-32768, -32768, 0, 0));
    send_point(pt_of(-32768, -32768, 0, 1));
    drain();

    // nearest point, rank change without a new set
    write_rank(1);
    send_point(pt_of(7, 7, 0, 1));
    send_point(pt_of(-1, -1, 0, 1));
    send_point(pt_of(32767, -32768, 1, 1));
    send_point(pt_of(-1, 1, 0, 1));
    send_point(pt_of(1, -1, 0, 1));
    drain();

    // rank phases: deepest rank, small ranks, ranks that name no point
    plan_rank  = '{64, 2, 0, 65, 127, 1, 5, 33, 64, 0, 0, 0};
    plan_items = '{300, 220, 60, 60, 60, 200, 200, 200, 250, 150, 150, 150};
    plan_rep   = '{30, 70, 50, 50, 50, 60, 40, 30, 20, 50, 25, 75};
    plan_gaps  = '{1, 0, 1, 1, 0, 1, 0, 1, 1, 0, 1, 1};
    for (int p = 9; p < NUM_PHASES; p++) plan_rank[p] = $urandom_range(1, K_MAX);

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_rank(plan_rank[p][RANK_W-1:0]);
      rx_calm = (p % 4 == 3);
      // long result-side hold while the sender keeps going, filling the core
      if (p == 1) hold_req = 1'b1;
      run_sets(plan_items[p], plan_rep[p], plan_gaps[p]);
      drain();
    end

    $display("points sent %0d, result words %0d (%0d with a held k-th point)",
             items_seen, results_seen, valid_seen);
    $display("inserts into a full store %0d, words still owed %0d", overflow_seen, pending);
    if (errors == 0 && pending == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
